### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the triac phase-angle dimmer.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked on the rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (prop)) \
    else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) !(cond)) \
    else $error("forbidden condition seen");

`endif

### hw/rtl/tpad_pkg.sv
// Package of the triac phase-angle dimmer: widths, constants, codes and the
// per-channel control struct. No dependencies.
package tpad_pkg;

  localparam int NUM_CHANNELS       = 4;
  localparam int SAMPLES_TO_AVERAGE = 10;

  localparam int DLY_W  = 14;
  localparam int HOLD_W = 10;
  localparam int CNT_W  = 20;
  localparam int SUM_W  = 24;
  localparam int SMP_W  = 4;
  localparam int MODE_W = 2;
  localparam int CH_W   = 2;
  localparam int GATE_W = 4;

  localparam logic [DLY_W-1:0]  LIMIT_50HZ = DLY_W'(9600);
  localparam logic [DLY_W-1:0]  LIMIT_60HZ = DLY_W'(7500);
  localparam int                AVG_THRESHOLD = 9800;
  // The floor average exceeds the threshold exactly when the sum reaches this.
  localparam logic [SUM_W-1:0]  SUM_THRESHOLD =
    SUM_W'((AVG_THRESHOLD + 1) * SAMPLES_TO_AVERAGE);
  localparam logic [DLY_W-1:0]  FIRE_MAX = {DLY_W{1'b1}};
  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX = {SUM_W{1'b1}};

  localparam logic [DLY_W-1:0]  LOW_LIMIT_RST = DLY_W'(500);
  localparam logic [HOLD_W-1:0] HOLD_TIME_RST = HOLD_W'(20);

  localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ON   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_OFF  = 2'd3;

  localparam int CFG_AW = 3;
  localparam logic REG_LOW_LIMIT = 1'b0;
  localparam logic REG_HOLD_TIME = 1'b1;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic              tick;
    logic              run_edge;
    logic              set_dly;
    logic              en_wr;
    logic              en_val;
    logic [DLY_W-1:0]  delay;
    logic [HOLD_W-1:0] hold;
    logic [DLY_W-1:0]  limit;
  } chan_ctrl_t;

endpackage

### hw/rtl/triac_phase_angle_dimmer_unit.sv
// Channel     | Direction | Beat contents
// in_         | slave     | tuser: mode; tdata: ac_level, channel, delay_us
// out_        | master    | tdata: gate_lines, calibrated, line_limit
// cfg_        | APB slave | low_limit at 0x0, hold_time at 0x4
//
// Every input beat gives exactly one output beat; one beat per cycle while unstalled.
// Each beat passes an input register, then the state update and result register.
// Synchronous active-low reset; calibration restarts after reset.
// A stalled output holds the result register and, once the input register is full,
// the input side; the per-channel timers advance only on tick beats.
// Top level of the triac phase-angle dimmer. Depends on tpad_pkg, tpad_channel
// and assert_macros.svh.
`include "assert_macros.svh"

module triac_phase_angle_dimmer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [0] ac_level, [2:1] channel, [16:3] delay_us, rest zero
  input  logic [tpad_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] mode
  input  logic [tpad_pkg::MODE_W-1:0]     in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [3:0] gate_lines, [4] calibrated, [18:5] line_limit, rest zero
  output logic [tpad_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tpad_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import tpad_pkg::*;

  // Configuration registers.
  logic [DLY_W-1:0]  low_limit_r;
  logic [HOLD_W-1:0] hold_time_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_HOLD_TIME) ? 32'(hold_time_r) : 32'(low_limit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_limit_r <= LOW_LIMIT_RST;
      hold_time_r <= HOLD_TIME_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_LOW_LIMIT) begin
        low_limit_r <= cfg_pwdata[DLY_W-1:0];
      end else begin
        hold_time_r <= cfg_pwdata[HOLD_W-1:0];
      end
    end
  end

  // Input register.
  logic              in_valid_r;
  logic [MODE_W-1:0] mode_r;
  logic              level_r;
  logic [CH_W-1:0]   chan_r;
  logic [DLY_W-1:0]  dly_r;
  logic              step;
  logic              in_acc;

  assign step      = in_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !in_valid_r || step;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_acc) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r  <= in_tuser;
      level_r <= in_tdata[0];
      chan_r  <= in_tdata[2:1];
      dly_r   <= in_tdata[16:3];
    end
  end

  // Line measurement and zero-cross detection.
  logic              prev_level_r, prev_level_nxt;
  logic              calibrating_r, calibrating_nxt;
  logic              first_seen_r, first_seen_nxt;
  logic [CNT_W-1:0]  icount_r, icount_nxt, icount_inc;
  logic [SUM_W-1:0]  isum_r, isum_nxt, isum_add;
  logic [SUM_W:0]    isum_ext;
  logic [SMP_W-1:0]  samples_r, samples_nxt;
  logic [DLY_W-1:0]  high_limit_r, high_limit_nxt;
  logic              is_tick;
  logic              zc_edge;

  assign is_tick    = (mode_r == MODE_TICK);
  assign zc_edge    = prev_level_r && !level_r;
  assign icount_inc = (icount_r < COUNT_MAX) ? icount_r + CNT_W'(1) : icount_r;
  assign isum_ext   = {1'b0, isum_r} + (SUM_W+1)'(icount_inc);
  assign isum_add   = isum_ext[SUM_W] ? SUM_MAX : isum_ext[SUM_W-1:0];

  always_comb begin
    prev_level_nxt  = prev_level_r;
    calibrating_nxt = calibrating_r;
    first_seen_nxt  = first_seen_r;
    icount_nxt      = icount_r;
    isum_nxt        = isum_r;
    samples_nxt     = samples_r;
    high_limit_nxt  = high_limit_r;
    if (is_tick) begin
      prev_level_nxt = level_r;
      if (calibrating_r) begin
        icount_nxt = icount_inc;
        if (zc_edge) begin
          icount_nxt = '0;
          if (!first_seen_r) begin
            first_seen_nxt = 1'b1;
          end else if (samples_r < SMP_W'(SAMPLES_TO_AVERAGE)) begin
            isum_nxt    = isum_add;
            samples_nxt = samples_r + SMP_W'(1);
            if (samples_nxt >= SMP_W'(SAMPLES_TO_AVERAGE)) begin
              high_limit_nxt  = (isum_add >= SUM_THRESHOLD) ? LIMIT_50HZ : LIMIT_60HZ;
              calibrating_nxt = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r  <= 1'b1;
      calibrating_r <= 1'b1;
      first_seen_r  <= 1'b0;
      icount_r      <= '0;
      isum_r        <= '0;
      samples_r     <= '0;
      high_limit_r  <= LIMIT_50HZ;
    end else if (step) begin
      prev_level_r  <= prev_level_nxt;
      calibrating_r <= calibrating_nxt;
      first_seen_r  <= first_seen_nxt;
      icount_r      <= icount_nxt;
      isum_r        <= isum_nxt;
      samples_r     <= samples_nxt;
      high_limit_r  <= high_limit_nxt;
    end
  end

  // Delay clamp: upper limit first, then the lower limit wins.
  logic [DLY_W-1:0] dly_hi, dly_clamped;

  assign dly_hi      = (dly_r > high_limit_r) ? high_limit_r : dly_r;
  assign dly_clamped = (dly_hi < low_limit_r) ? low_limit_r : dly_hi;

  // Channels.
  logic [NUM_CHANNELS-1:0] active_nxt;

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    chan_ctrl_t ctrl;
    logic       hit;

    assign hit = !is_tick && (chan_r == CH_W'(c));

    always_comb begin
      ctrl.tick     = is_tick;
      ctrl.run_edge = zc_edge && !calibrating_r;
      ctrl.set_dly  = hit && (mode_r == MODE_SET);
      ctrl.en_wr    = hit && ((mode_r == MODE_ON) || (mode_r == MODE_OFF));
      ctrl.en_val   = (mode_r == MODE_ON);
      ctrl.delay    = dly_clamped;
      ctrl.hold     = hold_time_r;
      ctrl.limit    = high_limit_r;
    end

    tpad_channel u_chan (
      .clk        (clk),
      .rst_n      (rst_n),
      .step       (step),
      .ctrl       (ctrl),
      .active_nxt (active_nxt[c])
    );
  end

  // Result register.
  logic [GATE_W-1:0] gates_nxt;

  assign gates_nxt = GATE_W'(active_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (step) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_tdata <= OUT_DATA_W'({high_limit_nxt, !calibrating_nxt, gates_nxt});
    end
  end

  `ASSERT_PROP(a_calib_done_sticky, clk, rst_n, !calibrating_r |=> !calibrating_r)
  `ASSERT_PROP(a_limit_legal, clk, rst_n,
    (high_limit_r == LIMIT_50HZ) || (high_limit_r == LIMIT_60HZ))
  `ASSERT_NEVER(a_limit_only_after_calib, clk, rst_n,
    (high_limit_r != LIMIT_50HZ) && calibrating_r)

endmodule

### hw/rtl/tpad_channel.sv
// One gate channel of the dimmer: delay setting, enable, firing timer and pulse.
// Depends on tpad_pkg.
module tpad_channel (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  tpad_pkg::chan_ctrl_t ctrl,
  output logic               active_nxt
);
  import tpad_pkg::*;

  logic [DLY_W-1:0]  delay_r, delay_nxt;
  logic              enabled_r, enabled_nxt;
  logic              running_r, running_nxt;
  logic [DLY_W-1:0]  count_r, count_nxt;
  logic [HOLD_W-1:0] pulse_r, pulse_nxt;
  logic [DLY_W-1:0]  count_inc;

  assign count_inc = (count_r < FIRE_MAX) ? count_r + DLY_W'(1) : count_r;

  always_comb begin
    delay_nxt   = delay_r;
    enabled_nxt = enabled_r;
    running_nxt = running_r;
    count_nxt   = count_r;
    pulse_nxt   = pulse_r;
    if (ctrl.tick) begin
      if (pulse_r != '0) begin
        pulse_nxt = pulse_r - HOLD_W'(1);
      end
      if (running_r) begin
        count_nxt = count_inc;
        if (count_inc >= delay_r) begin
          running_nxt = 1'b0;
          pulse_nxt   = ctrl.hold;
        end
      end
      if (ctrl.run_edge) begin
        pulse_nxt = '0;
        if (enabled_r && (delay_r < ctrl.limit)) begin
          running_nxt = 1'b1;
          count_nxt   = '0;
        end
      end
    end
    if (ctrl.set_dly) begin
      delay_nxt = ctrl.delay;
    end
    if (ctrl.en_wr) begin
      enabled_nxt = ctrl.en_val;
      pulse_nxt   = '0;
    end
  end

  assign active_nxt = (pulse_nxt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r   <= '0;
      enabled_r <= 1'b0;
      running_r <= 1'b0;
      count_r   <= '0;
      pulse_r   <= '0;
    end else if (step) begin
      delay_r   <= delay_nxt;
      enabled_r <= enabled_nxt;
      running_r <= running_nxt;
      count_r   <= count_nxt;
      pulse_r   <= pulse_nxt;
    end
  end

endmodule
